FILE: rtl/pal_pkg.sv
// Package for the positional array list: sizes, op and status codes,
// and word fitting helpers. No dependencies.
`default_nettype none

package pal_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;

  // Port widths fixed by the interface
  localparam int OP_W       = 3;
  localparam int POS_W      = 7;
  localparam int VAL_W      = 32;
  localparam int ST_W       = 2;
  localparam int LEN_PORT_W = 7;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELPOS = 3'd2;
  localparam logic [OP_W-1:0] OP_DELVAL = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  // Sign-extend the input value, keep the low WORD_BITS bits
  function automatic logic [WORD_BITS-1:0] fit_word(input logic signed [VAL_W-1:0] v);
    logic [63:0] x;
    x = {{(64-VAL_W){v[VAL_W-1]}}, v};
    return x[WORD_BITS-1:0];
  endfunction

  // Stored word zero-extended or truncated to the element port
  function automatic logic [VAL_W-1:0] to_elem(input logic [WORD_BITS-1:0] w);
    logic [63:0] x;
    x = 64'(w);
    return x[VAL_W-1:0];
  endfunction

  function automatic logic [LEN_PORT_W-1:0] to_len(input logic [CNT_W-1:0] c);
    logic [CNT_W+LEN_PORT_W-1:0] x;
    x = {{LEN_PORT_W{1'b0}}, c};
    return x[LEN_PORT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pal_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/positional_array_list.sv
// Positional array list: ordered signed words in one synchronous RAM.
// Append, clear, tail insert, refused items, spare codes and delete-by-value on an empty
// list go straight to the result; read, insert at p, delete at p and delete-by-value
// scan the RAM (delete-by-value does one RAM read per entry).
// One item at a time: the input stalls from accept until the result is loaded, longer
// while the output stalls. Reset clears the length and handshakes, not the RAM.
`default_nettype none

module positional_array_list (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pal_pkg::OP_W-1:0]             op_i,
  input  logic [pal_pkg::POS_W-1:0]            position_i,
  input  logic signed [pal_pkg::VAL_W-1:0]     value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pal_pkg::VAL_W-1:0]     element_o,
  output logic [pal_pkg::ST_W-1:0]             status_o,
  output logic [pal_pkg::LEN_PORT_W-1:0]       removed_count_o,
  output logic [pal_pkg::LEN_PORT_W-1:0]       list_length_o,
  output logic                                 is_empty_o,
  output logic                                 is_full_o
);

  import pal_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]           st_q, st_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 more_q, more_d;
  logic                 rv_q, rv_d;
  logic                 out_vld_q;

  logic [OP_W-1:0]      op_q, op_d;
  logic [ADDR_W-1:0]    pos_q, pos_d;
  logic [WORD_BITS-1:0] val_q, val_d;
  logic [ADDR_W-1:0]    rd_q, rd_d;
  logic [ADDR_W-1:0]    end_q, end_d;
  logic [ADDR_W-1:0]    ri_q, ri_d;
  logic [CNT_W-1:0]     wr_q, wr_d;
  logic [WORD_BITS-1:0] elem_q, elem_d;
  logic [ST_W-1:0]      stat_q, stat_d;
  logic [CNT_W-1:0]     rem_q, rem_d;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 re;
  logic [ADDR_W-1:0]    raddr;
  logic [WORD_BITS-1:0] rdata;

  logic [CMP_W-1:0]     pos_ext, cnt_ext, pm1;
  logic [CNT_W-1:0]     cm1;
  logic [ADDR_W-1:0]    pidx, cidx;
  logic                 full;
  logic                 out_load;

  assign pos_ext  = CMP_W'(position_i);
  assign cnt_ext  = CMP_W'(cnt_q);
  assign pm1      = pos_ext - 1'b1;
  assign cm1      = cnt_q - 1'b1;
  assign pidx     = pm1[ADDR_W-1:0];
  assign cidx     = cm1[ADDR_W-1:0];
  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign out_load = (st_q == S_DONE) && (!out_vld_q || !out_stall_i);

  assign in_stall_o = (st_q != S_IDLE);

  pal_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_pal_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Moves stream through the RAM: read one entry per cycle, write it back in the next
  // cycle. Writes always land behind the read pointer, so no address is read and
  // written in the same cycle.
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    more_d = more_q;
    rv_d   = 1'b0;
    op_d   = op_q;
    pos_d  = pos_q;
    val_d  = val_q;
    rd_d   = rd_q;
    end_d  = end_q;
    ri_d   = ri_q;
    wr_d   = wr_q;
    elem_d = elem_q;
    stat_d = stat_q;
    rem_d  = rem_q;
    we     = 1'b0;
    waddr  = '0;
    wdata  = '0;
    re     = 1'b0;
    raddr  = rd_q;

    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = op_i;
          val_d  = fit_word(value_i);
          elem_d = '0;
          stat_d = ST_OK;
          rem_d  = '0;
          st_d   = S_DONE;
          case (op_i)
            OP_APPEND: begin
              if (full) begin
                stat_d = ST_FULL;
              end else begin
                we    = 1'b1;
                waddr = cnt_q[ADDR_W-1:0];
                wdata = fit_word(value_i);
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_INSERT: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
                stat_d = ST_RANGE;
              end else if (full) begin
                stat_d = ST_FULL;
              end else if (pos_ext == cnt_ext + 1'b1) begin
                // insert at the tail: nothing to move
                we    = 1'b1;
                waddr = cnt_q[ADDR_W-1:0];
                wdata = fit_word(value_i);
                cnt_d = cnt_q + 1'b1;
              end else begin
                pos_d  = pidx;
                rd_d   = cidx;
                end_d  = pidx;
                more_d = 1'b1;
                st_d   = S_SCAN;
              end
            end
            OP_DELPOS: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                stat_d = ST_RANGE;
              end else begin
                pos_d  = pidx;
                rd_d   = pidx;
                end_d  = cidx;
                more_d = 1'b1;
                st_d   = S_SCAN;
              end
            end
            OP_DELVAL: begin
              if (cnt_q == '0) begin
                stat_d = ST_NOTFOUND;
              end else begin
                rd_d   = '0;
                end_d  = cidx;
                wr_d   = '0;
                more_d = 1'b1;
                st_d   = S_SCAN;
              end
            end
            OP_READ: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                stat_d = ST_RANGE;
              end else begin
                rd_d   = pidx;
                end_d  = pidx;
                more_d = 1'b1;
                st_d   = S_SCAN;
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (more_q) begin
          re    = 1'b1;
          raddr = rd_q;
          rv_d  = 1'b1;
          ri_d  = rd_q;
          if (rd_q == end_q) begin
            more_d = 1'b0;
          end else if (op_q == OP_INSERT) begin
            rd_d = rd_q - 1'b1;
          end else begin
            rd_d = rd_q + 1'b1;
          end
        end

        if (rv_q) begin
          case (op_q)
            OP_INSERT: begin
              we    = 1'b1;
              waddr = ri_q + 1'b1;
              wdata = rdata;
            end
            OP_DELPOS: begin
              if (ri_q == pos_q) begin
                elem_d = rdata;
              end else begin
                we    = 1'b1;
                waddr = ri_q - 1'b1;
                wdata = rdata;
              end
            end
            OP_DELVAL: begin
              // compact the survivors toward the head
              if (rdata != val_q) begin
                we    = 1'b1;
                waddr = wr_q[ADDR_W-1:0];
                wdata = rdata;
                wr_d  = wr_q + 1'b1;
              end
            end
            OP_READ: begin
              elem_d = rdata;
            end
            default: ;
          endcase
        end

        if (!more_q && !rv_q) begin
          st_d = S_DONE;
          case (op_q)
            OP_INSERT: st_d = S_WRITE;
            OP_DELPOS: cnt_d = cnt_q - 1'b1;
            OP_DELVAL: begin
              cnt_d  = wr_q;
              rem_d  = cnt_q - wr_q;
              stat_d = (wr_q == cnt_q) ? ST_NOTFOUND : ST_OK;
            end
            default: ;
          endcase
        end
      end

      S_WRITE: begin
        we    = 1'b1;
        waddr = pos_q;
        wdata = val_q;
        cnt_d = cnt_q + 1'b1;
        st_d  = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          st_d = S_IDLE;
        end
      end

      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      cnt_q     <= '0;
      more_q    <= 1'b0;
      rv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      more_q <= more_d;
      rv_q   <= rv_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    rd_q   <= rd_d;
    end_q  <= end_d;
    ri_q   <= ri_d;
    wr_q   <= wr_d;
    elem_q <= elem_d;
    stat_q <= stat_d;
    rem_q  <= rem_d;
    if (out_load) begin
      element_o       <= to_elem(elem_q);
      status_o        <= stat_q;
      removed_count_o <= to_len(rem_q);
      list_length_o   <= to_len(cnt_q);
      is_empty_o      <= (cnt_q == '0);
      is_full_o       <= full;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

FILE: rtl/pal_checker.sv
// Port-level assertions for the positional array list, bound to the top level.
// Depends on pal_pkg.
`default_nettype none

module pal_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [pal_pkg::VAL_W-1:0]        element_o,
  input logic [pal_pkg::ST_W-1:0]         status_o,
  input logic [pal_pkg::LEN_PORT_W-1:0]   removed_count_o,
  input logic [pal_pkg::LEN_PORT_W-1:0]   list_length_o,
  input logic                             is_empty_o,
  input logic                             is_full_o
);

  import pal_pkg::*;

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(element_o) && $stable(status_o))
    else $error("result item changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (list_length_o == '0)))
    else $error("empty flag disagrees with length");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_full_o |-> (list_length_o == LEN_PORT_W'(DEPTH)))
    else $error("full flag with wrong length");

  // errors never carry an element or a removal count
  a_ok_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (removed_count_o != '0 || element_o != '0) |-> (status_o == ST_OK))
    else $error("payload on a refused item");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> is_full_o)
    else $error("full status on a list that is not full");

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .element_o      (element_o),
  .status_o       (status_o),
  .removed_count_o(removed_count_o),
  .list_length_o  (list_length_o),
  .is_empty_o     (is_empty_o),
  .is_full_o      (is_full_o)
);

`default_nettype wire
